@@ hdl/hdlc_frame_bit_encoder_defines.svh @@
// Assertion macros shared by the HDLC frame bit encoder RTL.
`ifndef HDLC_FRAME_BIT_ENCODER_DEFINES_SVH
`define HDLC_FRAME_BIT_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS
`define HFBE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("hfbe: assertion failed");
`define HFBE_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("hfbe: assertion failed");
`else
`define HFBE_ASSERT(lbl, prop)
`define HFBE_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ hdl/hfbe_pkg.sv @@
// Types and constants shared by the HDLC frame bit encoder modules.
package hfbe_pkg;

    localparam logic [15:0] CRC_POLY  = 16'h8408;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [2:0]  STUFF_RUN = 3'd5;

    typedef struct packed {
        logic init;
        logic step;
        logic bit_in;
    } crc_ctrl_t;

    typedef struct packed {
        logic       load;
        logic       step;
        logic [7:0] load_val;
    } shift_ctrl_t;

    typedef struct packed {
        logic cur_bit;
        logic first_pos;
        logic last_pos;
    } shift_stat_t;

endpackage

@@ hdl/hfbe_crc.sv @@
// Bit-serial reflected CRC-16 unit, one payload bit per step.
module hfbe_crc (
    input  logic               aclk,
    input  logic               aresetn,
    input  hfbe_pkg::crc_ctrl_t ctrl,
    output logic [15:0]        crc,
    output logic [15:0]        crc_upd
);
    import hfbe_pkg::*;

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        fb;

    // Value the register takes if the current bit is shifted in.
    assign fb      = crc_reg[0] ^ ctrl.bit_in;
    assign crc_upd = {1'b0, crc_reg[15:1]} ^ (fb ? CRC_POLY : 16'h0000);

    always_comb begin
        crc_next = crc_reg;
        if (ctrl.init) begin
            crc_next = CRC_INIT;
        end else if (ctrl.step) begin
            crc_next = crc_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_INIT;
        end else begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

@@ hdl/hfbe_shifter.sv @@
// Shared byte shifter that hands out one bit per step, LSB first.
module hfbe_shifter (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  hfbe_pkg::shift_ctrl_t ctrl,
    output hfbe_pkg::shift_stat_t stat
);
    import hfbe_pkg::*;

    logic [7:0] sh_reg;
    logic [7:0] sh_next;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;

    always_comb begin
        sh_next  = sh_reg;
        cnt_next = cnt_reg;
        if (ctrl.load) begin
            sh_next  = ctrl.load_val;
            cnt_next = 3'd0;
        end else if (ctrl.step) begin
            sh_next  = {1'b0, sh_reg[7:1]};
            cnt_next = cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        sh_reg <= sh_next;
        if (!aresetn) begin
            cnt_reg <= 3'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    assign stat.cur_bit   = sh_reg[0];
    assign stat.first_pos = (cnt_reg == 3'd0);
    assign stat.last_pos  = (cnt_reg == 3'd7);

endmodule

@@ hdl/hdlc_frame_bit_encoder.sv @@
// Top level of the HDLC frame bit encoder: sequencer, stuffing and output word register.
// An accepted word loads the shifter, whose bits then go to the output word register.
// Throughput: one line bit per cycle while m_ready does not hold off, from a single
// shared byte shifter; the next word waits until all bits are out. Bits per word:
// 8 to 10 mid-frame, up to 17 with the opening flag, up to 44 if it closes the frame.
// Reset (aresetn low, synchronous): idle, outside a frame, CRC at 0xFFFF, no word pending.
module hdlc_frame_bit_encoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_out_bit,
    output logic       m_frame_begin,
    output logic       m_frame_end,
    output logic       m_run_last
);
    import hfbe_pkg::*;

`include "hdlc_frame_bit_encoder_defines.svh"

    // Sequencer phases: each non-idle phase walks one byte through the shifter.
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_OFLAG = 3'd1;
    localparam logic [2:0] PH_DATA  = 3'd2;
    localparam logic [2:0] PH_FCSLO = 3'd3;
    localparam logic [2:0] PH_FCSHI = 3'd4;
    localparam logic [2:0] PH_CFLAG = 3'd5;

    logic [2:0] ph_reg,      ph_next;
    logic [7:0] data_reg,    data_next;
    logic       last_reg,    last_next;
    logic       inframe_reg, inframe_next;
    logic [2:0] ones_reg,    ones_next;
    logic       stuff_reg,   stuff_next;

    logic       m_valid_reg, m_valid_next;
    logic       m_bit_reg,   m_bit_next;
    logic       m_begin_reg, m_begin_next;
    logic       m_end_reg,   m_end_next;
    logic       m_rlast_reg, m_rlast_next;

    logic        out_free;
    logic        accept;
    logic        emit;
    logic        stuff_set;
    logic [2:0]  ones_inc;
    logic [15:0] crc;
    logic [15:0] crc_upd;

    crc_ctrl_t   crc_ctrl;
    shift_ctrl_t sh_ctrl;
    shift_stat_t sh_stat;

    hfbe_crc u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (crc_ctrl),
        .crc     (crc),
        .crc_upd (crc_upd)
    );

    hfbe_shifter u_shifter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (sh_ctrl),
        .stat    (sh_stat)
    );

    // The output word register frees up when it is empty or being taken this cycle.
    assign out_free = !m_valid_reg || m_ready;
    // A new input word is taken only once every bit of the previous one is out,
    // including a stuffed zero that may still trail the final data bit.
    assign s_ready  = (ph_reg == PH_IDLE) && !stuff_reg;
    assign accept   = s_valid && s_ready;
    // A bit is produced whenever there is one to send and room to put it.
    assign emit     = ((ph_reg != PH_IDLE) || stuff_reg) && out_free;
    assign ones_inc = ones_reg + 3'd1;

    always_comb begin
        ph_next      = ph_reg;
        data_next    = data_reg;
        last_next    = last_reg;
        inframe_next = inframe_reg;
        ones_next    = ones_reg;
        stuff_next   = stuff_reg;
        stuff_set    = 1'b0;

        m_valid_next = m_valid_reg;
        m_bit_next   = m_bit_reg;
        m_begin_next = m_begin_reg;
        m_end_next   = m_end_reg;
        m_rlast_next = m_rlast_reg;

        crc_ctrl = '0;
        sh_ctrl  = '0;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (accept) begin
            data_next = s_data_byte;
            last_next = s_last_byte;
            if (!inframe_reg) begin
                // First word of a frame: restart the CRC and open with a flag.
                ph_next          = PH_OFLAG;
                sh_ctrl.load     = 1'b1;
                sh_ctrl.load_val = FLAG_BYTE;
                crc_ctrl.init    = 1'b1;
                ones_next        = 3'd0;
                inframe_next     = 1'b1;
            end else begin
                ph_next          = PH_DATA;
                sh_ctrl.load     = 1'b1;
                sh_ctrl.load_val = s_data_byte;
            end
        end

        if (emit) begin
            m_valid_next = 1'b1;
            m_begin_next = 1'b0;
            m_end_next   = 1'b0;
            m_rlast_next = 1'b0;
            if (stuff_reg) begin
                // A stuffed zero goes first; in idle it is the tail of the word.
                m_bit_next   = 1'b0;
                m_rlast_next = (ph_reg == PH_IDLE);
                stuff_next   = 1'b0;
                ones_next    = 3'd0;
            end else begin
                m_bit_next   = sh_stat.cur_bit;
                sh_ctrl.step = 1'b1;
                // Payload and CRC bits are stuffed; flag bits are not.
                if (ph_reg inside {PH_DATA, PH_FCSLO, PH_FCSHI}) begin
                    if (sh_stat.cur_bit) begin
                        if (ones_inc == STUFF_RUN) begin
                            stuff_set  = 1'b1;
                            stuff_next = 1'b1;
                            ones_next  = 3'd0;
                        end else begin
                            ones_next = ones_inc;
                        end
                    end else begin
                        ones_next = 3'd0;
                    end
                end
                case (ph_reg)
                    PH_OFLAG: begin
                        m_begin_next = sh_stat.first_pos;
                        if (sh_stat.last_pos) begin
                            ph_next          = PH_DATA;
                            sh_ctrl.load     = 1'b1;
                            sh_ctrl.load_val = data_reg;
                        end
                    end
                    PH_DATA: begin
                        crc_ctrl.step   = 1'b1;
                        crc_ctrl.bit_in = sh_stat.cur_bit;
                        if (sh_stat.last_pos) begin
                            if (last_reg) begin
                                // CRC after this final payload bit, complemented.
                                ph_next          = PH_FCSLO;
                                sh_ctrl.load     = 1'b1;
                                sh_ctrl.load_val = ~crc_upd[7:0];
                            end else begin
                                ph_next      = PH_IDLE;
                                m_rlast_next = !stuff_set;
                            end
                        end
                    end
                    PH_FCSLO: begin
                        if (sh_stat.last_pos) begin
                            ph_next          = PH_FCSHI;
                            sh_ctrl.load     = 1'b1;
                            sh_ctrl.load_val = ~crc[15:8];
                        end
                    end
                    PH_FCSHI: begin
                        if (sh_stat.last_pos) begin
                            ph_next          = PH_CFLAG;
                            sh_ctrl.load     = 1'b1;
                            sh_ctrl.load_val = FLAG_BYTE;
                        end
                    end
                    PH_CFLAG: begin
                        if (sh_stat.last_pos) begin
                            // Closing flag done: the frame is over.
                            m_end_next    = 1'b1;
                            m_rlast_next  = 1'b1;
                            ph_next       = PH_IDLE;
                            inframe_next  = 1'b0;
                            ones_next     = 3'd0;
                            crc_ctrl.init = 1'b1;
                        end
                    end
                    default: begin
                        ph_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg   <= data_next;
        last_reg   <= last_next;
        m_bit_reg  <= m_bit_next;
        m_begin_reg <= m_begin_next;
        m_end_reg  <= m_end_next;
        m_rlast_reg <= m_rlast_next;
        if (!aresetn) begin
            ph_reg      <= PH_IDLE;
            inframe_reg <= 1'b0;
            ones_reg    <= 3'd0;
            stuff_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            ph_reg      <= ph_next;
            inframe_reg <= inframe_next;
            ones_reg    <= ones_next;
            stuff_reg   <= stuff_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_bit     = m_bit_reg;
    assign m_frame_begin = m_begin_reg;
    assign m_frame_end   = m_end_reg;
    assign m_run_last    = m_rlast_reg;

    `HFBE_ASSERT(a_ones_below_run, ones_reg < STUFF_RUN)
    `HFBE_ASSERT(a_busy_after_accept, accept |=> !s_ready)
    `HFBE_ASSERT(a_stuffed_bit_zero, (emit && stuff_reg) |=> (m_valid && !m_out_bit))
    `HFBE_ASSERT(a_end_closes_word, (m_valid && m_frame_end) |-> (m_run_last && !m_out_bit))
    `HFBE_ASSERT(a_begin_not_end, m_valid |-> !(m_frame_begin && m_frame_end))
    `HFBE_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> (s_ready && !m_valid))

endmodule
